FILE: rtl/segment_segment_distance_core_macros.svh
// Assertion helpers used by the segment distance core.
`ifndef SEGMENT_SEGMENT_DISTANCE_CORE_MACROS_SVH
`define SEGMENT_SEGMENT_DISTANCE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/ssd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_pkg
// Widths, constants and payload types of the segment distance pipeline.
// ----------------------------------------------------------------------------
package ssd_pkg;

   localparam int COORD_W         = 16;
   localparam int COORD_FRAC_BITS = 8;
   localparam int PARAM_FRAC_BITS = 16;
   localparam int THR_W           = 16;
   localparam int DIFF_W          = COORD_W + 1;
   localparam int DOT_W           = 2 * COORD_W + 3;
   localparam int NUM_W           = 2 * DOT_W;
   localparam int PARAM_W         = PARAM_FRAC_BITS + 1;
   localparam int DIST_W          = 18;
   localparam int COMP_W          = DIFF_W + PARAM_FRAC_BITS + 2;
   localparam int RND_W           = COMP_W - PARAM_FRAC_BITS;
   localparam int SUM_W           = 2 * RND_W + 2;
   localparam int ROOT_W          = SUM_W / 2;
   localparam int REM_W           = ROOT_W + 3;

   localparam logic [THR_W-1:0]   THR_RESET = THR_W'(1);
   localparam logic [NUM_W-1:0]   UNIT_SQ   = NUM_W'(1) << (2 * COORD_FRAC_BITS);
   localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1) << PARAM_FRAC_BITS;
   localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};

   typedef struct packed {
      logic [2:0][COORD_W-1:0] u;
      logic [2:0][COORD_W-1:0] v;
      logic [2:0][DIFF_W-1:0]  w;
   } geo_type;

   typedef struct packed {
      logic signed [DOT_W-1:0] a;
      logic signed [DOT_W-1:0] b;
      logic signed [DOT_W-1:0] c;
      logic signed [DOT_W-1:0] d;
      logic signed [DOT_W-1:0] e;
   } dots_type;

   typedef struct packed {
      logic             zero;
      logic             one;
      logic [NUM_W-2:0] num;
      logic [NUM_W-2:0] den;
   } quot_type;

endpackage
`default_nettype wire

FILE: rtl/segment_segment_distance_core.sv
// Pipeline: 3 dot, 5 solve, 16 divider, 25 distance and square-root stages
// and 1 output register between request accept and rsp_valid.
// Throughput: one request per cycle; the whole pipeline holds while a
// response sits in the output register and rsp_ready is low.
// Reset: synchronous, clears all stage valid bits and sets zero_threshold to 1.
`default_nettype none
// ----------------------------------------------------------------------------
// segment_segment_distance_core
// Closest points and distance between two 3D segments, fixed point.
// ----------------------------------------------------------------------------
`include "segment_segment_distance_core_macros.svh"

module segment_segment_distance_core (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [ssd_pkg::COORD_W-1:0]        req_a_start_x,
   input  wire logic [ssd_pkg::COORD_W-1:0]        req_a_start_y,
   input  wire logic [ssd_pkg::COORD_W-1:0]        req_a_start_z,
   input  wire logic [ssd_pkg::COORD_W-1:0]        req_a_dir_x,
   input  wire logic [ssd_pkg::COORD_W-1:0]        req_a_dir_y,
   input  wire logic [ssd_pkg::COORD_W-1:0]        req_a_dir_z,
   input  wire logic [ssd_pkg::COORD_W-1:0]        req_b_start_x,
   input  wire logic [ssd_pkg::COORD_W-1:0]        req_b_start_y,
   input  wire logic [ssd_pkg::COORD_W-1:0]        req_b_start_z,
   input  wire logic [ssd_pkg::COORD_W-1:0]        req_b_dir_x,
   input  wire logic [ssd_pkg::COORD_W-1:0]        req_b_dir_y,
   input  wire logic [ssd_pkg::COORD_W-1:0]        req_b_dir_z,

   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [ssd_pkg::DIST_W-1:0]              rsp_distance,
   output logic [ssd_pkg::PARAM_W-1:0]             rsp_param_a,
   output logic [ssd_pkg::PARAM_W-1:0]             rsp_param_b,

   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [ssd_pkg::THR_W-1:0]          csr_zero_threshold
);

   logic                               adv;
   logic [ssd_pkg::THR_W-1:0]          thr_ff;

   logic                               dot_valid, solve_valid, div_valid, dist_valid;
   ssd_pkg::geo_type                   dot_geo, solve_geo, div_geo;
   ssd_pkg::dots_type                  dot_dots;
   ssd_pkg::quot_type                  solve_qa, solve_qb;
   logic [ssd_pkg::PARAM_W-1:0]        div_pa, div_pb;
   logic [ssd_pkg::DIST_W-1:0]         dist_value;

   logic                               rsp_valid_ff;
   logic [ssd_pkg::DIST_W-1:0]         rsp_distance_ff;
   logic [ssd_pkg::PARAM_W-1:0]        rsp_param_a_ff, rsp_param_b_ff;
   logic [ssd_pkg::PARAM_W-1:0]        pa_ff [ssd_pkg::ROOT_W + 5];
   logic [ssd_pkg::PARAM_W-1:0]        pb_ff [ssd_pkg::ROOT_W + 5];

   // advance every stage unless a finished response is held
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= ssd_pkg::THR_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_zero_threshold;
      end
   end

   ssd_dot u_dot (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid && adv),
      .start_a  ({req_a_start_z, req_a_start_y, req_a_start_x}),
      .dir_a    ({req_a_dir_z, req_a_dir_y, req_a_dir_x}),
      .start_b  ({req_b_start_z, req_b_start_y, req_b_start_x}),
      .dir_b    ({req_b_dir_z, req_b_dir_y, req_b_dir_x}),
      .out_valid(dot_valid),
      .out_geo  (dot_geo),
      .out_dots (dot_dots)
   );

   ssd_solve u_solve (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .thr      (thr_ff),
      .in_valid (dot_valid),
      .in_geo   (dot_geo),
      .in_dots  (dot_dots),
      .out_valid(solve_valid),
      .out_geo  (solve_geo),
      .out_qa   (solve_qa),
      .out_qb   (solve_qb)
   );

   ssd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (solve_valid),
      .in_geo   (solve_geo),
      .in_qa    (solve_qa),
      .in_qb    (solve_qb),
      .out_valid(div_valid),
      .out_geo  (div_geo),
      .out_pa   (div_pa),
      .out_pb   (div_pb)
   );

   ssd_dist u_dist (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (div_valid),
      .in_geo      (div_geo),
      .in_pa       (div_pa),
      .in_pb       (div_pb),
      .out_valid   (dist_valid),
      .out_distance(dist_value)
   );

   // carry both parameters alongside the distance stages
   always_ff @(posedge clock) begin
      if (adv) begin
         pa_ff[0] <= div_pa;
         pb_ff[0] <= div_pb;
         for (int s = 1; s < ssd_pkg::ROOT_W + 5; s++) begin
            pa_ff[s] <= pa_ff[s-1];
            pb_ff[s] <= pb_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dist_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_distance_ff <= dist_value;
         rsp_param_a_ff  <= pa_ff[ssd_pkg::ROOT_W + 4];
         rsp_param_b_ff  <= pb_ff[ssd_pkg::ROOT_W + 4];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_param_a  = rsp_param_a_ff;
   assign rsp_param_b  = rsp_param_b_ff;

   `SSD_ASSERT_NOW(a_param_a_range, clock, reset, rsp_valid_ff, rsp_param_a_ff <= ssd_pkg::PARAM_ONE, "param_a above one")
   `SSD_ASSERT_NOW(a_param_b_range, clock, reset, rsp_valid_ff, rsp_param_b_ff <= ssd_pkg::PARAM_ONE, "param_b above one")
   `SSD_ASSERT_NOW(a_stall_blocks_intake, clock, reset, rsp_valid_ff && !rsp_ready, !req_ready, "request taken while response held")
   `SSD_ASSERT_NEXT(a_thr_write, clock, reset, csr_valid && csr_ready, thr_ff == $past(csr_zero_threshold), "threshold write lost")

endmodule
`default_nettype wire

FILE: rtl/ssd_dot.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_dot
// Three stages: start difference, component products, dot product sums.
// ----------------------------------------------------------------------------
module ssd_dot (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   adv,
   input  wire logic                                   in_valid,
   input  wire logic [2:0][ssd_pkg::COORD_W-1:0]       start_a,
   input  wire logic [2:0][ssd_pkg::COORD_W-1:0]       dir_a,
   input  wire logic [2:0][ssd_pkg::COORD_W-1:0]       start_b,
   input  wire logic [2:0][ssd_pkg::COORD_W-1:0]       dir_b,
   output logic                                        out_valid,
   output ssd_pkg::geo_type                            out_geo,
   output ssd_pkg::dots_type                           out_dots
);

   localparam int CW = ssd_pkg::COORD_W;
   localparam int DW = ssd_pkg::DIFF_W;

   logic [2:0]              valid_ff;
   ssd_pkg::geo_type        geo1_in, geo1_ff, geo2_ff, geo3_ff;
   logic signed [2*CW-1:0]  uu_in [3], uv_in [3], vv_in [3];
   logic signed [2*CW-1:0]  uu_ff [3], uv_ff [3], vv_ff [3];
   logic signed [CW+DW-1:0] uw_in [3], vw_in [3];
   logic signed [CW+DW-1:0] uw_ff [3], vw_ff [3];
   ssd_pkg::dots_type       dots_in, dots_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         geo1_in.u[k] = dir_a[k];
         geo1_in.v[k] = dir_b[k];
         geo1_in.w[k] = {start_a[k][CW-1], start_a[k]} - {start_b[k][CW-1], start_b[k]};
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         uu_in[k] = $signed(geo1_ff.u[k]) * $signed(geo1_ff.u[k]);
         uv_in[k] = $signed(geo1_ff.u[k]) * $signed(geo1_ff.v[k]);
         vv_in[k] = $signed(geo1_ff.v[k]) * $signed(geo1_ff.v[k]);
         uw_in[k] = $signed(geo1_ff.u[k]) * $signed(geo1_ff.w[k]);
         vw_in[k] = $signed(geo1_ff.v[k]) * $signed(geo1_ff.w[k]);
      end
   end

   always_comb begin
      dots_in.a = ssd_pkg::DOT_W'(uu_ff[0]) + ssd_pkg::DOT_W'(uu_ff[1])
                + ssd_pkg::DOT_W'(uu_ff[2]);
      dots_in.b = ssd_pkg::DOT_W'(uv_ff[0]) + ssd_pkg::DOT_W'(uv_ff[1])
                + ssd_pkg::DOT_W'(uv_ff[2]);
      dots_in.c = ssd_pkg::DOT_W'(vv_ff[0]) + ssd_pkg::DOT_W'(vv_ff[1])
                + ssd_pkg::DOT_W'(vv_ff[2]);
      dots_in.d = ssd_pkg::DOT_W'(uw_ff[0]) + ssd_pkg::DOT_W'(uw_ff[1])
                + ssd_pkg::DOT_W'(uw_ff[2]);
      dots_in.e = ssd_pkg::DOT_W'(vw_ff[0]) + ssd_pkg::DOT_W'(vw_ff[1])
                + ssd_pkg::DOT_W'(vw_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         geo1_ff <= geo1_in;
         geo2_ff <= geo1_ff;
         geo3_ff <= geo2_ff;
         for (int k = 0; k < 3; k++) begin
            uu_ff[k] <= uu_in[k];
            uv_ff[k] <= uv_in[k];
            vv_ff[k] <= vv_in[k];
            uw_ff[k] <= uw_in[k];
            vw_ff[k] <= vw_in[k];
         end
         dots_ff <= dots_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_geo   = geo3_ff;
   assign out_dots  = dots_ff;

endmodule
`default_nettype wire

FILE: rtl/ssd_solve.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_solve
// Five stages: cross products, determinant and numerators, parallel and
// extent clamps, then zero/one classification of both parameter fractions.
// ----------------------------------------------------------------------------
module ssd_solve (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         adv,
   input  wire logic [ssd_pkg::THR_W-1:0]    thr,
   input  wire logic                         in_valid,
   input  wire ssd_pkg::geo_type             in_geo,
   input  wire ssd_pkg::dots_type            in_dots,
   output logic                              out_valid,
   output ssd_pkg::geo_type                  out_geo,
   output ssd_pkg::quot_type                 out_qa,
   output ssd_pkg::quot_type                 out_qb
);

   localparam int NW = ssd_pkg::NUM_W;

   function automatic ssd_pkg::quot_type make_quot(
      input logic signed [ssd_pkg::NUM_W-1:0] num,
      input logic signed [ssd_pkg::NUM_W-1:0] den,
      input logic signed [ssd_pkg::NUM_W-1:0] lim
   );
      ssd_pkg::quot_type q;
      logic signed [ssd_pkg::NUM_W-1:0] mag;
      mag    = num[ssd_pkg::NUM_W-1] ? -num : num;
      q.zero = (mag < lim) || den[ssd_pkg::NUM_W-1] || (den == '0)
             || num[ssd_pkg::NUM_W-1] || (num == '0);
      q.one  = (num >= den);
      q.num  = num[ssd_pkg::NUM_W-2:0];
      q.den  = den[ssd_pkg::NUM_W-2:0];
      return q;
   endfunction

   logic [4:0]            valid_ff;
   logic signed [NW-1:0]  thr_ext;

   ssd_pkg::geo_type      geo4_ff, geo5_ff, geo6_ff, geo7_ff, geo8_ff;
   ssd_pkg::dots_type     dots4_ff, dots5_ff, dots6_ff;

   logic signed [NW-1:0]  ac_in, bb_in, be_in, cd_in, ae_in, bd_in;
   logic signed [NW-1:0]  ac_ff, bb_ff, be_ff, cd_ff, ae_ff, bd_ff;
   logic signed [NW-1:0]  den5_ff, sn5_ff, tn5_ff;
   logic signed [NW-1:0]  b5_ext, c5_ext, e5_ext;
   logic signed [NW-1:0]  sn6_in, sd6_in, tn6_in, td6_in;
   logic signed [NW-1:0]  sn6_ff, sd6_ff, tn6_ff, td6_ff;
   logic signed [NW-1:0]  a6_ext, b6_ext, d6_ext, nd6, bd6;
   logic signed [NW-1:0]  sn7_in, sd7_in, tn7_in, td7_in;
   logic signed [NW-1:0]  sn7_ff, sd7_ff, tn7_ff, td7_ff;
   ssd_pkg::quot_type     qa_ff, qb_ff;

   assign thr_ext = {{(NW - ssd_pkg::THR_W){1'b0}}, thr};

   assign ac_in = in_dots.a * in_dots.c;
   assign bb_in = in_dots.b * in_dots.b;
   assign be_in = in_dots.b * in_dots.e;
   assign cd_in = in_dots.c * in_dots.d;
   assign ae_in = in_dots.a * in_dots.e;
   assign bd_in = in_dots.b * in_dots.d;

   assign b5_ext = NW'(dots5_ff.b);
   assign c5_ext = NW'(dots5_ff.c);
   assign e5_ext = NW'(dots5_ff.e);

   // parallel test, then clamp s to the extent of segment A
   always_comb begin
      sn6_in = sn5_ff;
      sd6_in = den5_ff;
      tn6_in = tn5_ff;
      td6_in = den5_ff;
      if (den5_ff < thr_ext) begin
         sn6_in = '0;
         sd6_in = ssd_pkg::UNIT_SQ;
         tn6_in = e5_ext;
         td6_in = c5_ext;
      end else if (sn5_ff[NW-1]) begin
         sn6_in = '0;
         tn6_in = e5_ext;
         td6_in = c5_ext;
      end else if (sn5_ff > den5_ff) begin
         sn6_in = den5_ff;
         tn6_in = e5_ext + b5_ext;
         td6_in = c5_ext;
      end
   end

   assign a6_ext = NW'(dots6_ff.a);
   assign b6_ext = NW'(dots6_ff.b);
   assign d6_ext = NW'(dots6_ff.d);
   assign nd6    = -d6_ext;
   assign bd6    = b6_ext - d6_ext;

   // clamp t to segment B and recompute s against the clamped end
   always_comb begin
      sn7_in = sn6_ff;
      sd7_in = sd6_ff;
      tn7_in = tn6_ff;
      td7_in = td6_ff;
      if (tn6_ff[NW-1]) begin
         tn7_in = '0;
         if (nd6[NW-1]) begin
            sn7_in = '0;
         end else if (nd6 > a6_ext) begin
            sn7_in = sd6_ff;
         end else begin
            sn7_in = nd6;
            sd7_in = a6_ext;
         end
      end else if (tn6_ff > td6_ff) begin
         tn7_in = td6_ff;
         if (bd6[NW-1]) begin
            sn7_in = '0;
         end else if (bd6 > a6_ext) begin
            sn7_in = sd6_ff;
         end else begin
            sn7_in = bd6;
            sd7_in = a6_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         geo4_ff  <= in_geo;
         dots4_ff <= in_dots;
         ac_ff    <= ac_in;
         bb_ff    <= bb_in;
         be_ff    <= be_in;
         cd_ff    <= cd_in;
         ae_ff    <= ae_in;
         bd_ff    <= bd_in;

         geo5_ff  <= geo4_ff;
         dots5_ff <= dots4_ff;
         den5_ff  <= ac_ff - bb_ff;
         sn5_ff   <= be_ff - cd_ff;
         tn5_ff   <= ae_ff - bd_ff;

         geo6_ff  <= geo5_ff;
         dots6_ff <= dots5_ff;
         sn6_ff   <= sn6_in;
         sd6_ff   <= sd6_in;
         tn6_ff   <= tn6_in;
         td6_ff   <= td6_in;

         geo7_ff  <= geo6_ff;
         sn7_ff   <= sn7_in;
         sd7_ff   <= sd7_in;
         tn7_ff   <= tn7_in;
         td7_ff   <= td7_in;

         geo8_ff  <= geo7_ff;
         qa_ff    <= make_quot(sn7_ff, sd7_ff, thr_ext);
         qb_ff    <= make_quot(tn7_ff, td7_ff, thr_ext);
      end
   end

   assign out_valid = valid_ff[4];
   assign out_geo   = geo8_ff;
   assign out_qa    = qa_ff;
   assign out_qb    = qb_ff;

endmodule
`default_nettype wire

FILE: rtl/ssd_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_div
// Pipelined restoring divider, two lanes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ssd_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           adv,
   input  wire logic                           in_valid,
   input  wire ssd_pkg::geo_type               in_geo,
   input  wire ssd_pkg::quot_type              in_qa,
   input  wire ssd_pkg::quot_type              in_qb,
   output logic                                out_valid,
   output ssd_pkg::geo_type                    out_geo,
   output logic [ssd_pkg::PARAM_W-1:0]         out_pa,
   output logic [ssd_pkg::PARAM_W-1:0]         out_pb
);

   localparam int STEPS = ssd_pkg::PARAM_FRAC_BITS;
   localparam int RW    = ssd_pkg::NUM_W - 1;

   typedef struct packed {
      logic             zero;
      logic             one;
      logic [RW-1:0]    rem;
      logic [RW-1:0]    den;
      logic [STEPS-1:0] quo;
   } lane_type;

   logic [STEPS-1:0] valid_ff;
   ssd_pkg::geo_type geo_ff [STEPS];
   lane_type         src    [STEPS][2];
   lane_type         lane_in[STEPS][2];
   lane_type         lane_ff[STEPS][2];
   logic [RW:0]      shifted[STEPS][2];
   logic [RW:0]      diff   [STEPS][2];
   logic [ssd_pkg::PARAM_W-1:0] param[2];

   always_comb begin
      src[0][0] = '{zero: in_qa.zero, one: in_qa.one, rem: in_qa.num, den: in_qa.den,
                    quo: '0};
      src[0][1] = '{zero: in_qb.zero, one: in_qb.one, rem: in_qb.num, den: in_qb.den,
                    quo: '0};
      for (int s = 1; s < STEPS; s++) begin
         for (int l = 0; l < 2; l++) begin
            src[s][l] = lane_ff[s-1][l];
         end
      end
      for (int s = 0; s < STEPS; s++) begin
         for (int l = 0; l < 2; l++) begin
            shifted[s][l] = {src[s][l].rem, 1'b0};
            diff[s][l]    = shifted[s][l] - {1'b0, src[s][l].den};
            lane_in[s][l] = src[s][l];
            if (!diff[s][l][RW]) begin
               lane_in[s][l].rem = diff[s][l][RW-1:0];
               lane_in[s][l].quo = {src[s][l].quo[STEPS-2:0], 1'b1};
            end else begin
               lane_in[s][l].rem = shifted[s][l][RW-1:0];
               lane_in[s][l].quo = {src[s][l].quo[STEPS-2:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         if (lane_ff[STEPS-1][l].zero) begin
            param[l] = '0;
         end else if (lane_ff[STEPS-1][l].one) begin
            param[l] = ssd_pkg::PARAM_ONE;
         end else begin
            param[l] = {1'b0, lane_ff[STEPS-1][l].quo};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[STEPS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         geo_ff[0] <= in_geo;
         for (int s = 1; s < STEPS; s++) begin
            geo_ff[s] <= geo_ff[s-1];
         end
         for (int s = 0; s < STEPS; s++) begin
            for (int l = 0; l < 2; l++) begin
               lane_ff[s][l] <= lane_in[s][l];
            end
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_geo   = geo_ff[STEPS-1];
   assign out_pa    = param[0];
   assign out_pb    = param[1];

endmodule
`default_nettype wire

FILE: rtl/ssd_dist.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_dist
// Closest-point difference vector, rounding, sum of squares and a pipelined
// digit-by-digit square root, one root bit per stage.
// ----------------------------------------------------------------------------
module ssd_dist (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           adv,
   input  wire logic                           in_valid,
   input  wire ssd_pkg::geo_type               in_geo,
   input  wire logic [ssd_pkg::PARAM_W-1:0]    in_pa,
   input  wire logic [ssd_pkg::PARAM_W-1:0]    in_pb,
   output logic                                out_valid,
   output logic [ssd_pkg::DIST_W-1:0]          out_distance
);

   localparam int P      = ssd_pkg::PARAM_FRAC_BITS;
   localparam int CW     = ssd_pkg::COMP_W;
   localparam int RNW    = ssd_pkg::RND_W;
   localparam int SW     = ssd_pkg::SUM_W;
   localparam int QW     = ssd_pkg::ROOT_W;
   localparam int MW     = ssd_pkg::REM_W;
   localparam int STAGES = 5 + QW;
   localparam logic [CW-1:0] HALF = CW'(1) << (P - 1);

   typedef struct packed {
      logic [MW-1:0] rem;
      logic [QW-1:0] root;
      logic [SW-1:0] x;
   } root_type;

   logic [STAGES-1:0]     valid_ff;
   logic signed [CW-1:0]  up_in [3], vp_in [3];
   logic signed [CW-1:0]  up_ff [3], vp_ff [3];
   logic [ssd_pkg::DIFF_W-1:0] w_ff [3];
   logic signed [CW-1:0]  comp_in [3], comp_ff [3];
   logic [CW-1:0]         mag [3], rsum [3];
   logic [RNW-1:0]        rnd_ff [3];
   logic [2*RNW-1:0]      sq_ff [3];
   logic [SW-1:0]         sum_ff;
   root_type              src    [QW];
   root_type              root_in[QW];
   root_type              root_ff[QW];
   logic [MW-1:0]         cur    [QW];
   logic [MW:0]           diff   [QW];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         up_in[k]   = $signed(in_geo.u[k]) * $signed({1'b0, in_pa});
         vp_in[k]   = $signed(in_geo.v[k]) * $signed({1'b0, in_pb});
         comp_in[k] = (CW'($signed(w_ff[k])) <<< P) + up_ff[k] - vp_ff[k];
         mag[k]     = comp_ff[k][CW-1] ? -comp_ff[k] : comp_ff[k];
         rsum[k]    = mag[k] + HALF;
      end
   end

   always_comb begin
      src[0] = '{rem: '0, root: '0, x: sum_ff};
      for (int s = 1; s < QW; s++) begin
         src[s] = root_ff[s-1];
      end
      for (int s = 0; s < QW; s++) begin
         cur[s]  = {src[s].rem[MW-3:0], src[s].x[SW-1 -: 2]};
         diff[s] = {1'b0, cur[s]} - {2'b00, src[s].root, 2'b01};
         root_in[s].x = {src[s].x[SW-3:0], 2'b00};
         if (!diff[s][MW]) begin
            root_in[s].rem  = diff[s][MW-1:0];
            root_in[s].root = {src[s].root[QW-2:0], 1'b1};
         end else begin
            root_in[s].rem  = cur[s];
            root_in[s].root = {src[s].root[QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            up_ff[k]   <= up_in[k];
            vp_ff[k]   <= vp_in[k];
            w_ff[k]    <= in_geo.w[k];
            comp_ff[k] <= comp_in[k];
            rnd_ff[k]  <= rsum[k][CW-1:P];
            sq_ff[k]   <= rnd_ff[k] * rnd_ff[k];
         end
         sum_ff <= SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);
         for (int s = 0; s < QW; s++) begin
            root_ff[s] <= root_in[s];
         end
      end
   end

   assign out_valid    = valid_ff[STAGES-1];
   assign out_distance = (root_ff[QW-1].root > QW'(ssd_pkg::DIST_MAX))
                       ? ssd_pkg::DIST_MAX : root_ff[QW-1].root[ssd_pkg::DIST_W-1:0];

endmodule
`default_nettype wire
